// ===== rtl/wpgq_pkg.sv =====
// Shared types and constants for the worker pool grant queue.
package wpgq_pkg;

  localparam int unsigned RankW        = 4;
  localparam int unsigned RankMax      = 16;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned NumRanksDef  = 16;
  localparam int unsigned WaitDepthDef = 16;

  localparam logic [MaskW-1:0] MaskReset = 16'hFFFE;

  localparam logic KindRequest = 1'b0;
  localparam logic KindRelease = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StGranted      = 3'd0,
    StQueued       = 3'd1,
    StIdled        = 3'd2,
    StIdledGranted = 3'd3,
    StIgnored      = 3'd4
  } status_e;

  // Controls for the waiter queue.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } wq_ctrl_t;

endpackage

// ===== rtl/worker_pool_grant_queue.sv =====
// Top level of the worker pool grant queue: idle pool, busy map and waiter queue.
//
//  channel  | ports                                      | transfer when
//  ---------+--------------------------------------------+-------------------------------
//  item in  | start, kind_i, source_rank_i, busy         | start high and busy low
//  result   | result_valid_o, status_o, dest_rank_o,     | every cycle result_valid_o is
//           | worker_rank_o                              | high (one-cycle strobe)
//  config   | cfg_valid_i, cfg_data_i, cfg_ready_o       | cfg_valid_i and cfg_ready_o
//
//  An accepted item is registered, processed in one pass of logic and its result is
//  registered again; a new item can enter every cycle in which busy is low.
//  After reset and after each worker_mask write a load sweep refills the idle pool, one
//  rank per cycle across min(NUM_RANKS,16) slots with busy high; reset loads mask 0xFFFE.
//  The result side has no backpressure, so nothing inside ever stalls.
module worker_pool_grant_queue #(
  parameter int unsigned NUM_RANKS  = wpgq_pkg::NumRanksDef,
  parameter int unsigned WAIT_DEPTH = wpgq_pkg::WaitDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [wpgq_pkg::RankW-1:0]    source_rank_i,
  output logic                          result_valid_o,
  output logic [wpgq_pkg::StatusW-1:0]  status_o,
  output logic [wpgq_pkg::RankW-1:0]    dest_rank_o,
  output logic [wpgq_pkg::RankW-1:0]    worker_rank_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wpgq_pkg::MaskW-1:0]    cfg_data_i
);
  import wpgq_pkg::*;

  // Only ranks that fit both the rank field and NUM_RANKS can be workers.
  localparam int unsigned RankSlots = (NUM_RANKS < RankMax) ? NUM_RANKS : RankMax;
  localparam int unsigned IdxW      = $clog2(RankSlots);
  localparam int unsigned ICntW     = $clog2(RankSlots + 1);
  localparam int unsigned ISumW     = ICntW + 1;
  localparam logic [IdxW-1:0]  LastIdx   = IdxW'(RankSlots - 1);
  localparam logic [ISumW-1:0] SlotsSum  = ISumW'(RankSlots);
  localparam logic [MaskW-1:0] SlotMask  = MaskW'((32'd1 << RankSlots) - 32'd1);

  // Configuration and load sweep
  logic [MaskW-1:0] mask_q;
  logic             loading_q;
  logic [IdxW-1:0]  load_cnt_q;
  logic [MaskW-1:0] live_mask;
  logic             cfg_wr;

  // Idle pool FIFO (register array, one entry per rank slot)
  logic [RankW-1:0] idle_mem_q [RankSlots];
  logic [IdxW-1:0]  idle_head_q, idle_head_d;
  logic [ICntW-1:0] idle_cnt_q, idle_cnt_d;
  logic [ISumW-1:0] idle_tail_sum, idle_tail_wrap;
  logic [IdxW-1:0]  idle_tail;
  logic             idle_push, idle_pop;
  logic [RankW-1:0] idle_push_rank, pop_worker;

  logic [RankMax-1:0] busy_map_q, busy_map_d;

  // Input register
  logic             accept;
  logic             req_vld_q;
  logic             req_kind_q;
  logic [RankW-1:0] req_src_q;
  logic             src_ok;

  // Result register
  logic             res_vld_q;
  status_e          res_status_q, res_status_d;
  logic [RankW-1:0] res_dest_q, res_dest_d;
  logic [RankW-1:0] res_worker_q, res_worker_d;

  // Waiter queue
  wq_ctrl_t         wq_ctrl;
  logic [RankW-1:0] wq_head_rank;
  logic             wq_empty, wq_full;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign busy        = loading_q;
  assign accept      = start & ~busy;
  assign live_mask   = mask_q & SlotMask;
  assign src_ok      = live_mask[req_src_q];

  always_comb begin
    idle_tail_sum  = ISumW'(idle_head_q) + ISumW'(idle_cnt_q);
    idle_tail_wrap = (idle_tail_sum >= SlotsSum) ? (idle_tail_sum - SlotsSum)
                                                 : idle_tail_sum;
    idle_tail      = idle_tail_wrap[IdxW-1:0];
  end

  // A release into an empty pool that also serves a waiter hands back the same rank.
  assign pop_worker = (idle_cnt_q == '0) ? req_src_q : idle_mem_q[idle_head_q];

  // Item processing
  always_comb begin
    idle_push      = 1'b0;
    idle_push_rank = req_src_q;
    idle_pop       = 1'b0;
    busy_map_d     = busy_map_q;
    wq_ctrl        = '0;
    wq_ctrl.clear  = cfg_wr;
    res_status_d   = StIgnored;
    res_dest_d     = '0;
    res_worker_d   = '0;

    if (loading_q) begin
      idle_push      = live_mask[RankW'(load_cnt_q)];
      idle_push_rank = RankW'(load_cnt_q);
    end else if (req_vld_q && src_ok) begin
      if (req_kind_q == KindRequest) begin
        if (idle_cnt_q != '0) begin
          idle_pop                 = 1'b1;
          busy_map_d[pop_worker]   = 1'b1;
          res_status_d             = StGranted;
          res_dest_d               = req_src_q;
          res_worker_d             = pop_worker;
        end else if (!wq_full) begin
          wq_ctrl.push = 1'b1;
          res_status_d = StQueued;
        end
      end else if (busy_map_q[req_src_q]) begin
        busy_map_d[req_src_q] = 1'b0;
        idle_push             = 1'b1;
        res_status_d          = StIdled;
        if (!wq_empty) begin
          wq_ctrl.pop            = 1'b1;
          idle_pop               = 1'b1;
          busy_map_d[pop_worker] = 1'b1;
          res_status_d           = StIdledGranted;
          res_dest_d             = wq_head_rank;
          res_worker_d           = pop_worker;
        end
      end
    end

    if (cfg_wr) begin
      busy_map_d = '0;
    end
  end

  always_comb begin
    idle_head_d = idle_head_q;
    idle_cnt_d  = idle_cnt_q;
    if (cfg_wr) begin
      idle_head_d = '0;
      idle_cnt_d  = '0;
    end else begin
      if (idle_pop) begin
        idle_head_d = (idle_head_q == LastIdx) ? '0 : idle_head_q + IdxW'(1);
      end
      if (idle_push && !idle_pop) begin
        idle_cnt_d = idle_cnt_q + ICntW'(1);
      end else if (idle_pop && !idle_push) begin
        idle_cnt_d = idle_cnt_q - ICntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= MaskReset;
      loading_q   <= 1'b1;
      load_cnt_q  <= '0;
      idle_head_q <= '0;
      idle_cnt_q  <= '0;
      busy_map_q  <= '0;
      req_vld_q   <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mask_q     <= cfg_data_i;
        loading_q  <= 1'b1;
        load_cnt_q <= '0;
      end else if (loading_q) begin
        if (load_cnt_q == LastIdx) begin
          loading_q <= 1'b0;
        end else begin
          load_cnt_q <= load_cnt_q + IdxW'(1);
        end
      end
      idle_head_q <= idle_head_d;
      idle_cnt_q  <= idle_cnt_d;
      busy_map_q  <= busy_map_d;
      req_vld_q   <= accept;
      res_vld_q   <= req_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (idle_push && !cfg_wr) begin
      idle_mem_q[idle_tail] <= idle_push_rank;
    end
    if (accept) begin
      req_kind_q <= kind_i;
      req_src_q  <= source_rank_i;
    end
    res_status_q <= res_status_d;
    res_dest_q   <= res_dest_d;
    res_worker_q <= res_worker_d;
  end

  wpgq_wait_fifo #(
    .DEPTH(WAIT_DEPTH)
  ) u_wait_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (wq_ctrl),
    .push_rank_i(req_src_q),
    .head_rank_o(wq_head_rank),
    .empty_o    (wq_empty),
    .full_o     (wq_full)
  );

  assign result_valid_o = res_vld_q;
  assign status_o       = res_status_q;
  assign dest_rank_o    = res_dest_q;
  assign worker_rank_o  = res_worker_q;

  // Every result strobe comes from a start transfer that passed the input and result registers.
  a_result_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result strobe without a matching start transfer");

  // Each live worker is either idle or busy, never both, never neither.
  a_pool_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !loading_q |-> (32'(idle_cnt_q) + 32'($countones(busy_map_q))
                    == 32'($countones(live_mask))))
    else $error("idle count and busy map disagree with the worker mask");

  // Requesters only wait while the idle pool is empty.
  a_wait_only_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wq_empty |-> (idle_cnt_q == '0))
    else $error("waiters queued while idle workers exist");

endmodule

// ===== rtl/wpgq_wait_fifo.sv =====
// Waiter queue: circular buffer in a memory with a registered head read.
module wpgq_wait_fifo #(
  parameter int unsigned DEPTH = wpgq_pkg::WaitDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wpgq_pkg::wq_ctrl_t            ctrl_i,
  input  logic [wpgq_pkg::RankW-1:0]    push_rank_i,
  output logic [wpgq_pkg::RankW-1:0]    head_rank_o,
  output logic                          empty_o,
  output logic                          full_o
);
  import wpgq_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  logic [RankW-1:0] mem [DEPTH];
  logic [PtrW-1:0]  head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]  tail_sum, tail_wrap;
  logic [PtrW-1:0]  tail;
  logic [RankW-1:0] rd_q;

  always_comb begin
    tail_sum  = SumW'(head_q) + SumW'(cnt_q);
    tail_wrap = (tail_sum >= DepthSum) ? (tail_sum - DepthSum) : tail_sum;
    tail      = tail_wrap[PtrW-1:0];
  end

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      cnt_d  = '0;
    end else if (ctrl_i.push && !ctrl_i.pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      cnt_d  = cnt_q - CntW'(1);
      head_d = (head_q == LastPtr) ? '0 : head_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // Read is prefetched at the next head; a write landing there is forwarded.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      mem[tail] <= push_rank_i;
    end
    if (ctrl_i.push && !ctrl_i.clear && (tail == head_d)) begin
      rd_q <= push_rank_i;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign head_rank_o = rd_q;
  assign empty_o     = (cnt_q == '0);
  assign full_o      = (cnt_q == FullCnt);

endmodule
